// ===== design/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg: shared types for the sorted list store
// Operation and status codes, the per-cell command and the neighbour chain.
// ----------------------------------------------------------------------------
package sls_pkg;

	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_SORTED    = 3'd1,
		OP_INSERT_AT = 3'd2,
		OP_DELETE_AT = 3'd3,
		OP_READ_AT   = 3'd4,
		OP_READ_HEAD = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS_POS,
		CMD_INS_SEEN,
		CMD_DEL
	} cell_cmd_t;

	typedef struct packed {
		logic seen;
		logic tail_ge;
	} chain_t;

endpackage

// ===== design/sls_cell.sv =====
// ----------------------------------------------------------------------------
// sls_cell: one list slot
// Holds one entry, compares it with the broadcast value and takes its own,
// the new, the left or the right word on each update.
// ----------------------------------------------------------------------------
module sls_cell import sls_pkg::*; #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 32,
	parameter int PW         = 5
) (
	input  logic                         clk,
	input  cell_cmd_t                    cmd,
	input  logic signed [VALUE_BITS-1:0] ins_value,
	input  logic        [PW-1:0]         k,
	input  logic        [PW-1:0]         count,
	input  logic        [PW-1:0]         rd_pos,
	input  logic signed [VALUE_BITS-1:0] left_value,
	input  logic signed [VALUE_BITS-1:0] right_value,
	output logic signed [VALUE_BITS-1:0] value,
	input  chain_t                       chain_in,
	output chain_t                       chain_out,
	input  logic        [VALUE_BITS-1:0] rd_in,
	output logic        [VALUE_BITS-1:0] rd_out
);

	localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
	localparam logic [PW-1:0] NEXT_IDX = PW'(IDX + 1);

	logic signed [VALUE_BITS-1:0] entry_q;
	logic signed [VALUE_BITS-1:0] entry_d;
	logic                         ge;
	logic                         hit;
	logic                         is_last;

	assign value   = entry_q;
	assign ge      = entry_q >= ins_value;
	assign hit     = (IDX >= 1) && (MY_IDX < count) && ge;
	assign is_last = (count != '0) && (NEXT_IDX == count);

	assign chain_out.seen    = chain_in.seen | hit;
	assign chain_out.tail_ge = chain_in.tail_ge | (is_last & ~ge) | (is_last & (entry_q == ins_value));
	assign rd_out            = rd_in | ((MY_IDX == rd_pos) ? entry_q : '0);

	always_comb begin
		entry_d = entry_q;
		unique case (cmd)
			CMD_INS_POS: begin
				if (MY_IDX > k) entry_d = left_value;
				else if (MY_IDX == k) entry_d = ins_value;
			end
			CMD_INS_SEEN: begin
				if (chain_in.seen) entry_d = left_value;
				else if (hit) entry_d = ins_value;
			end
			CMD_DEL: begin
				if (MY_IDX >= k) entry_d = right_value;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== design/sorted_list_store.sv =====
// ----------------------------------------------------------------------------
// sorted_list_store: fixed-capacity ordered list of signed values
// A row of cells shifts entries up on insert and down on delete in one step.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, op, item_value,
//            position                                  word in
//   out      out_valid, out_stall, read_value,
//            list_length, status                       word out
//
// One word per cycle is sustained while the output is not stalled; the rate
// rests on the ripple through the cell row (search, tail and read).
// Reset clears the length and the output valid; entries need no clearing.
// A stalled output word holds, and the input stalls only while it is held.
// ----------------------------------------------------------------------------
module sorted_list_store import sls_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [2:0]  op,
	input  logic signed [31:0] item_value,
	input  logic        [3:0]  position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_value,
	output logic        [4:0]  list_length,
	output logic        [1:0]  status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_d;
	logic                         out_valid_q;
	logic signed [31:0]           read_value_q;
	logic [4:0]                   list_length_q;
	status_t                      status_q;

	logic                         acc;
	logic                         full;
	logic                         empty;
	logic                         pos_ok;
	logic                         front_le;
	logic [PW-1:0]                posx;
	logic [PW-1:0]                countx;
	logic signed [VALUE_BITS-1:0] v;
	logic [31:0]                  rd32;
	logic [4:0]                   len_d;
	logic                         rd_use;
	status_t                      status_d;
	cell_cmd_t                    cmd_d;
	cell_cmd_t                    cmd;
	logic [PW-1:0]                k;
	logic [PW-1:0]                rd_pos;

	logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
	chain_t                       chain [CAPACITY+1];
	logic [VALUE_BITS-1:0]        rd_chain [CAPACITY+1];

	assign acc       = in_valid & ~in_stall;
	assign in_stall  = out_valid_q & out_stall;
	assign out_valid = out_valid_q;

	assign full     = count_q == CAP_CNT;
	assign empty    = count_q == '0;
	assign posx     = PW'(position);
	assign countx   = PW'(count_q);
	assign pos_ok   = posx < countx;
	assign front_le = v <= cell_value[0];

	generate
		if (VALUE_BITS < 32) begin : g_narrow
			assign v    = item_value[VALUE_BITS-1:0];
			assign rd32 = {{(32-VALUE_BITS){rd_chain[CAPACITY][VALUE_BITS-1]}},
				rd_chain[CAPACITY]};
		end else if (VALUE_BITS == 32) begin : g_equal
			assign v    = item_value;
			assign rd32 = rd_chain[CAPACITY];
		end else begin : g_wide
			assign v    = {{(VALUE_BITS-32){item_value[31]}}, item_value};
			assign rd32 = rd_chain[CAPACITY][31:0];
		end
		if (CNT_W >= 5) begin : g_len_cut
			assign len_d = count_d[4:0];
		end else begin : g_len_ext
			assign len_d = {{(5-CNT_W){1'b0}}, count_d};
		end
	endgenerate

	always_comb begin
		cmd_d    = CMD_HOLD;
		k        = countx;
		rd_pos   = '0;
		rd_use   = 1'b0;
		status_d = ST_DONE;
		count_d  = count_q;
		unique case (op_t'(op))
			OP_APPEND: begin
				if (full) status_d = ST_FULL;
				else begin
					cmd_d   = CMD_INS_POS;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_SORTED: begin
				if (full) status_d = ST_FULL;
				else begin
					count_d = count_q + CNT_W'(1);
					priority if (empty || front_le) begin
						cmd_d = CMD_INS_POS;
						k     = '0;
					end else if (chain[CAPACITY].tail_ge) begin
						cmd_d = CMD_INS_POS;
					end else begin
						cmd_d = CMD_INS_SEEN;
					end
				end
			end
			OP_INSERT_AT: begin
				priority if (full) status_d = ST_FULL;
				else if (!pos_ok) status_d = ST_BAD;
				else begin
					cmd_d   = CMD_INS_POS;
					k       = posx;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE_AT: begin
				if (!pos_ok) status_d = ST_BAD;
				else begin
					cmd_d   = CMD_DEL;
					k       = posx;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ_AT: begin
				rd_pos = posx;
				if (!pos_ok) status_d = ST_BAD;
				else rd_use = 1'b1;
			end
			OP_READ_HEAD: begin
				if (empty) status_d = ST_BAD;
				else rd_use = 1'b1;
			end
			default: status_d = ST_BAD;
		endcase
	end

	assign cmd = acc ? cmd_d : CMD_HOLD;

	assign chain[0]    = '0;
	assign rd_chain[0] = '0;

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [VALUE_BITS-1:0] left_v;
			logic signed [VALUE_BITS-1:0] right_v;
			if (i == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_mid_l
				assign left_v = cell_value[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_v = '0;
			end else begin : g_mid_r
				assign right_v = cell_value[i+1];
			end
			sls_cell #(
				.IDX        (i),
				.VALUE_BITS (VALUE_BITS),
				.PW         (PW)
			) u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.ins_value   (v),
				.k           (k),
				.count       (countx),
				.rd_pos      (rd_pos),
				.left_value  (left_v),
				.right_value (right_v),
				.value       (cell_value[i]),
				.chain_in    (chain[i]),
				.chain_out   (chain[i+1]),
				.rd_in       (rd_chain[i]),
				.rd_out      (rd_chain[i+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) count_q <= count_d;
			if (acc) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_value_q  <= rd_use ? rd32 : '0;
			list_length_q <= len_d;
			status_q      <= status_d;
		end
	end

	assign read_value  = read_value_q;
	assign list_length = list_length_q;
	assign status      = status_q;

	logic [4:0] len_now;
	generate
		if (CNT_W >= 5) begin : g_now_cut
			assign len_now = count_q[4:0];
		end else begin : g_now_ext
			assign len_now = {{(5-CNT_W){1'b0}}, count_q};
		end
	endgenerate

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("list length above capacity");

	a_len_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> list_length_q == len_now)
		else $error("result length differs from held length");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> full)
		else $error("full status while list not full");

	a_bad_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && status_d == ST_BAD) |=> $stable(count_q))
		else $error("length changed on rejected word");

endmodule

// ===== tb/sorted_list_store_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_store_check: result checker for the sorted list store
// Watches both channels, keeps its own copy of the ordered list, predicts the
// reply to every accepted operation and compares each returned word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sorted_list_store_check import sls_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic        [2:0]  op,
	input  logic signed [31:0] item_value,
	input  logic        [3:0]  position,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] read_value,
	input  logic        [4:0]  list_length,
	input  logic        [1:0]  status,
	output int                 fail_count,
	output int                 replies_pending,
	output int                 done_seen,
	output int                 full_seen,
	output int                 bad_seen
);

	typedef struct {
		logic signed [31:0] value;
		logic        [4:0]  length;
		logic        [1:0]  code;
	} list_reply_t;

	logic signed [31:0] cells [CAPACITY];
	int                 held;
	list_reply_t        replies_due [$];
	int                 fails;
	int                 n_done;
	int                 n_full;
	int                 n_bad;

	// open a gap at slot by moving later entries up one cell
	function automatic void open_slot(input int slot, input logic signed [31:0] v);
		for (int i = held; i > slot; i--)
			cells[i] = cells[i - 1];
		cells[slot] = v;
		held++;
	endfunction

	task automatic apply_list_op(input logic [2:0] code, input logic signed [31:0] v,
			input logic [3:0] at, output list_reply_t r);
		int slot;
		r.value = '0;
		r.code  = ST_DONE;
		case (code)
			OP_APPEND: begin
				if (held >= CAPACITY)
					r.code = ST_FULL;
				else
					open_slot(held, v);
			end
			OP_SORTED: begin
				if (held >= CAPACITY) begin
					r.code = ST_FULL;
				end else if (held == 0 || v <= cells[0]) begin
					open_slot(0, v);
				end else if (v >= cells[held - 1]) begin
					open_slot(held, v);
				end else begin
					slot = 1;
					while (slot < held && cells[slot] < v)
						slot++;
					open_slot(slot, v);
				end
			end
			OP_INSERT_AT: begin
				if (held >= CAPACITY)
					r.code = ST_FULL;
				else if (int'(at) >= held)
					r.code = ST_BAD;
				else
					open_slot(int'(at), v);
			end
			OP_DELETE_AT: begin
				if (int'(at) >= held) begin
					r.code = ST_BAD;
				end else begin
					for (int i = int'(at); i + 1 < held; i++)
						cells[i] = cells[i + 1];
					held--;
				end
			end
			OP_READ_AT: begin
				if (int'(at) >= held)
					r.code = ST_BAD;
				else
					r.value = cells[at];
			end
			OP_READ_HEAD: begin
				if (held == 0)
					r.code = ST_BAD;
				else
					r.value = cells[0];
			end
			default: begin
				r.code = ST_BAD;
			end
		endcase
		r.length = held[4:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_reply_t predicted;
		list_reply_t oldest;
		if (!arst_n) begin
			held = 0;
			replies_due.delete();
			fails  = 0;
			n_done = 0;
			n_full = 0;
			n_bad  = 0;
			fail_count      <= 0;
			replies_pending <= 0;
			done_seen       <= 0;
			full_seen       <= 0;
			bad_seen        <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_list_op(op, item_value, position, predicted);
				replies_due.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("reply word arrived with no operation waiting");
					fails++;
				end else begin
					oldest = replies_due.pop_front();
					case (oldest.code)
						ST_DONE: n_done++;
						ST_FULL: n_full++;
						default: n_bad++;
					endcase
					if (read_value !== oldest.value) begin
						$error("read_value: expected %0d, got %0d", oldest.value, read_value);
						fails++;
					end
					if (list_length !== oldest.length) begin
						$error("list_length: expected %0d, got %0d", oldest.length,
							list_length);
						fails++;
					end
					if (status !== oldest.code) begin
						$error("status: expected %0d, got %0d", oldest.code, status);
						fails++;
					end
				end
			end
			fail_count      <= fails;
			replies_pending <= replies_due.size();
			done_seen       <= n_done;
			full_seen       <= n_full;
			bad_seen        <= n_bad;
		end
	end

endmodule

// ===== tb/sorted_list_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_store_test: top level of the sorted list store testbench
// Drives a directed run through the list's corner cases, then random bursts
// that fill and drain the list, with random gaps and output stalls. The
// checker beside the block predicts and compares; this module decides pass.
// ----------------------------------------------------------------------------
module sorted_list_store_test import sls_pkg::*;;

	localparam int          CAPACITY     = 16;
	localparam int          RANDOM_WORDS = 1250;
	localparam int          IDLE_LIMIT   = 1000;
	localparam logic [2:0]  OP_SPARE_6   = 3'd6;
	localparam logic [2:0]  OP_SPARE_7   = 3'd7;
	localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic        [2:0]  op         = '0;
	logic signed [31:0] item_value = '0;
	logic        [3:0]  position   = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [31:0] read_value;
	logic        [4:0]  list_length;
	logic        [1:0]  status;

	int fail_count;
	int replies_pending;
	int done_seen;
	int full_seen;
	int bad_seen;
	int idle_cycles = 0;
	int words_sent  = 0;
	bit steady      = 1'b0;

	always #5 clk = ~clk;

	sorted_list_store #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(32)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.item_value (item_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.list_length(list_length),
		.status     (status)
	);

	sorted_list_store_check #(
		.CAPACITY(CAPACITY)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.item_value     (item_value),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_value     (read_value),
		.list_length    (list_length),
		.status         (status),
		.fail_count     (fail_count),
		.replies_pending(replies_pending),
		.done_seen      (done_seen),
		.full_seen      (full_seen),
		.bad_seen       (bad_seen)
	);

	// random back-pressure on the reply channel
	always @(negedge clk) begin
		out_stall = !steady && ($urandom_range(0, 99) < 28);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("sorted_list_store_test NOT OK");
			$finish;
		end
	end

	// hold the word until accepted, then advance to the next falling edge
	task automatic send_word(input logic [2:0] code, input logic [31:0] v,
			input logic [3:0] at);
		while (!steady && $urandom_range(0, 99) < 28) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		op         = code;
		item_value = v;
		position   = at;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 8)) - 32'd4;
			1: begin
				case ($urandom_range(0, 3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int          fill_weight;
		int          pick;
		logic [2:0]  code;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list: every read, delete and insert-at is refused
		send_word(OP_READ_HEAD, '0, 4'd0);
		send_word(OP_READ_AT, '0, 4'd0);
		send_word(OP_DELETE_AT, '0, 4'd0);
		send_word(OP_INSERT_AT, 32'd9, 4'd0);
		// sorted insert: empty, tie with first, below first, end, middle, tie with last
		send_word(OP_SORTED, 32'd5, 4'd0);
		send_word(OP_SORTED, 32'd5, 4'd0);
		send_word(OP_SORTED, -32'sd100, 4'd0);
		send_word(OP_SORTED, VAL_MAX, 4'd0);
		send_word(OP_SORTED, 32'd6, 4'd0);
		send_word(OP_SORTED, VAL_MAX, 4'd0);
		send_word(OP_APPEND, VAL_MIN, 4'd0);
		send_word(OP_SORTED, 32'd0, 4'd0);
		send_word(OP_INSERT_AT, 32'd1, 4'd0);
		send_word(OP_INSERT_AT, 32'hA5A5_5A5A, 4'd7);
		send_word(OP_INSERT_AT, 32'd3, 4'd15);
		send_word(OP_READ_AT, '0, 4'd0);
		send_word(OP_READ_AT, '0, 4'd8);
		send_word(OP_READ_AT, '0, 4'd15);
		send_word(OP_READ_HEAD, '0, 4'd0);
		send_word(OP_DELETE_AT, '0, 4'd0);
		send_word(OP_DELETE_AT, '0, 4'd7);
		send_word(OP_DELETE_AT, '0, 4'd15);
		send_word(OP_SPARE_6, 32'd1, 4'd1);
		send_word(OP_SPARE_7, 32'd1, 4'd1);

		// each burst favours filling, churning or draining the list, picked at random
		fill_weight = 50;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: fill_weight = 85;
					1: fill_weight = 50;
					default: fill_weight = 15;
				endcase
			end
			steady = (n >= 500 && n < 800);
			pick = $urandom_range(0, 99);
			if (pick < fill_weight) begin
				case ($urandom_range(0, 2))
					0: code = OP_APPEND;
					1: code = OP_SORTED;
					default: code = OP_INSERT_AT;
				endcase
			end else if (pick >= 97) begin
				code = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
			end else begin
				case ($urandom_range(0, 2))
					0: code = OP_DELETE_AT;
					1: code = OP_READ_AT;
					default: code = OP_READ_HEAD;
				endcase
			end
			send_word(code, pick_value(), 4'($urandom_range(0, 15)));
		end
		steady   = 1'b0;
		in_valid = 1'b0;

		while (replies_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d list operations through fill, churn and drain bursts.", words_sent);
		$display("Replies: %0d done, %0d refused as full, %0d bad position or empty.",
			done_seen, full_seen, bad_seen);
		if (fail_count == 0)
			$display("sorted_list_store_test OK");
		else
			$display("sorted_list_store_test NOT OK");
		$finish;
	end

endmodule
